// ===== design/iqma_pkg.sv =====
`timescale 1ns / 1ps
package iqma_pkg;

    localparam int MAX_ITEMS_LOG2 = 20;

    localparam int CNT_W    = MAX_ITEMS_LOG2 + 1;
    localparam int CS_W     = MAX_ITEMS_LOG2 + 17;
    localparam int SREF_W   = MAX_ITEMS_LOG2 + 8;
    localparam int SSE_W    = MAX_ITEMS_LOG2 + 16;
    localparam int NUM_W    = CS_W + 16;
    localparam int STEP_W   = $clog2(NUM_W + 1);
    localparam int RES_W    = 24;
    localparam int MANT_W   = 32;
    localparam int NORM_W   = (CS_W > MANT_W) ? CS_W : MANT_W;
    localparam int E_W      = $clog2(NORM_W);
    localparam int FRAC_W   = 24;
    localparam int LOG_W    = E_W + FRAC_W;
    localparam int PROD_W   = LOG_W + 32;
    localparam int SNR_SHIFT = 46;
    localparam int Q_W      = PROD_W + 1 - SNR_SHIFT;
    localparam logic [31:0] SNR_K = 32'd3232284966;

    localparam logic [1:0] SEL_NC  = 2'd0;
    localparam logic [1:0] SEL_CQ  = 2'd1;
    localparam logic [1:0] SEL_MSE = 2'd2;

    typedef struct packed {
        logic [7:0] original_byte;
        logic [7:0] current_byte;
        logic       last;
    } iqma_in_t;

    typedef struct packed {
        logic [RES_W-1:0]  nc_ratio;
        logic [RES_W-1:0]  cq_ratio;
        logic [RES_W-1:0]  mean_sq_error;
        logic signed [15:0] snr_db;
        logic              snr_infinite;
        logic [CNT_W-1:0]  pair_count;
        logic              count_overflow;
    } iqma_out_t;

    typedef struct packed {
        logic       acc;
        logic       div_load;
        logic       div_step;
        logic       div_save;
        logic [1:0] div_sel;
        logic       log_load;
        logic       norm;
        logic       mant_load;
        logic       sqr;
        logic       log_save;
        logic       log_sel;
        logic       scale;
        logic       finish;
    } iqma_cmd_t;

    typedef struct packed {
        logic norm_done;
        logic sse_zero;
    } iqma_stat_t;

endpackage

// ===== design/image_quality_metric_accumulator_unit.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Payload      | Handshake
// in      | input     | iqma_in_t    | in_valid / in_stall
// out     | output    | iqma_out_t   | out_valid / out_stall
//
// A pair not marked last is accepted in the same cycle it is presented; pairs stream back to back.
// A last pair starts the result sequence: three passes of a shared restoring
// divider, then, unless the squared-error sum is zero, two log2 passes (each a
// normalize then 24 squarings) and one scaling multiply.
// in_stall stays high during that sequence and, at its end, while a prior result is still stalled.
// Reset clears all sums, counts, flags and the output valid.
module image_quality_metric_accumulator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  iqma_pkg::iqma_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output iqma_pkg::iqma_out_t out_data
);

    iqma_pkg::iqma_cmd_t  cmd;
    iqma_pkg::iqma_stat_t stat;

    iqma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    iqma_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

// ===== design/iqma_ctrl.sv =====
`timescale 1ns / 1ps
module iqma_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    input  logic                 out_stall,
    input  iqma_pkg::iqma_stat_t stat,
    output logic                 in_stall,
    output logic                 out_valid,
    output iqma_pkg::iqma_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DIVL  = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_LOGL  = 8'b0000_1000,
        S_NORM  = 8'b0001_0000,
        S_SQR   = 8'b0010_0000,
        S_SCALE = 8'b0100_0000,
        S_HOLD  = 8'b1000_0000
    } state_t;

    state_t                      state_reg, state_next;
    logic [iqma_pkg::STEP_W-1:0] step_reg, step_next;
    logic [1:0]                  dsel_reg, dsel_next;
    logic                        lsel_reg, lsel_next;
    logic                        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            dsel_reg      <= iqma_pkg::SEL_NC;
            lsel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            dsel_reg      <= dsel_next;
            lsel_reg      <= lsel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dsel_next  = dsel_reg;
        lsel_next  = lsel_reg;
        cmd        = '0;
        cmd.div_sel = dsel_reg;
        cmd.log_sel = lsel_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.acc = 1'b1;
                    if (in_last)
                    begin
                        dsel_next  = iqma_pkg::SEL_NC;
                        state_next = S_DIVL;
                    end
                end
            end
            S_DIVL:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == iqma_pkg::STEP_W'(iqma_pkg::NUM_W))
                begin
                    cmd.div_save = 1'b1;
                    if (dsel_reg == iqma_pkg::SEL_MSE)
                    begin
                        lsel_next  = 1'b0;
                        state_next = stat.sse_zero ? S_HOLD : S_LOGL;
                    end
                    else
                    begin
                        dsel_next  = dsel_reg + 2'd1;
                        state_next = S_DIVL;
                    end
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    step_next    = step_reg + 1'b1;
                end
            end
            S_LOGL:
            begin
                cmd.log_load = 1'b1;
                state_next   = S_NORM;
            end
            S_NORM:
            begin
                if (stat.norm_done)
                begin
                    cmd.mant_load = 1'b1;
                    step_next     = '0;
                    state_next    = S_SQR;
                end
                else
                begin
                    cmd.norm = 1'b1;
                end
            end
            S_SQR:
            begin
                if (step_reg == iqma_pkg::STEP_W'(iqma_pkg::FRAC_W))
                begin
                    cmd.log_save = 1'b1;
                    if (lsel_reg)
                    begin
                        state_next = S_SCALE;
                    end
                    else
                    begin
                        lsel_next  = 1'b1;
                        state_next = S_LOGL;
                    end
                end
                else
                begin
                    cmd.sqr   = 1'b1;
                    step_next = step_reg + 1'b1;
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_rise_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_HOLD))
        else $error("result appeared outside hold state");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (step_reg <= iqma_pkg::STEP_W'(iqma_pkg::NUM_W)))
        else $error("divider step count out of range");
    a_hold_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD && out_valid_reg && out_stall) |=> (state_reg == S_HOLD))
        else $error("result overwritten while stalled");

endmodule

// ===== design/iqma_dp.sv =====
`timescale 1ns / 1ps
module iqma_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  iqma_pkg::iqma_in_t   in_data,
    input  iqma_pkg::iqma_cmd_t  cmd,
    output iqma_pkg::iqma_stat_t stat,
    output iqma_pkg::iqma_out_t  out_data
);

    logic [iqma_pkg::CS_W-1:0]   scp_reg, src_reg;
    logic [iqma_pkg::SREF_W-1:0] sref_reg;
    logic [iqma_pkg::SSE_W-1:0]  sse_reg;
    logic [iqma_pkg::CNT_W-1:0]  cnt_reg;
    logic                        ovf_reg;

    logic [iqma_pkg::NUM_W-1:0]  num_reg;
    logic [iqma_pkg::CS_W-1:0]   rem_reg;
    logic [iqma_pkg::RES_W-1:0]  nc_reg, cq_reg, mse_reg;

    logic [iqma_pkg::NORM_W-1:0] norm_reg;
    logic [iqma_pkg::E_W-1:0]    e_reg;
    logic [iqma_pkg::MANT_W-1:0] m_reg;
    logic [iqma_pkg::FRAC_W-1:0] f_reg;
    logic [iqma_pkg::LOG_W-1:0]  ln_reg, ld_reg;
    logic [iqma_pkg::PROD_W-1:0] prod_reg;
    logic                        neg_reg;
    iqma_pkg::iqma_out_t         out_reg;

    logic [7:0]                  c, s, d;
    logic [15:0]                 cs_prod, cc_prod, dd_prod;
    logic [iqma_pkg::CS_W-1:0]   den;
    logic [iqma_pkg::NUM_W-1:0]  num_in;
    logic [iqma_pkg::CS_W:0]     trial;
    logic                        fits;
    logic [iqma_pkg::RES_W-1:0]  q_sat;
    logic [2*iqma_pkg::MANT_W-1:0] sq;
    logic [iqma_pkg::MANT_W:0]   sq_top;
    logic                        neg;
    logic [iqma_pkg::LOG_W-1:0]  mag;
    logic [iqma_pkg::PROD_W-1:0] scaled;
    logic [iqma_pkg::PROD_W:0]   rnd;
    logic [iqma_pkg::Q_W-1:0]    q;
    logic [15:0]                 snr;

    assign c = (in_data.original_byte == 8'd0) ? 8'd1 : in_data.original_byte;
    assign s = (in_data.current_byte == 8'd0) ? 8'd1 : in_data.current_byte;
    assign d = (c > s) ? (c - s) : (s - c);

    assign cs_prod = {8'd0, c} * {8'd0, s};
    assign cc_prod = {8'd0, c} * {8'd0, c};
    assign dd_prod = {8'd0, d} * {8'd0, d};

    always_comb
    begin
        case (cmd.div_sel)
            iqma_pkg::SEL_NC:
            begin
                den    = src_reg;
                num_in = {scp_reg, 16'd0};
            end
            iqma_pkg::SEL_CQ:
            begin
                den    = iqma_pkg::CS_W'(sref_reg);
                num_in = {scp_reg, 16'd0};
            end
            default:
            begin
                den    = iqma_pkg::CS_W'(cnt_reg);
                num_in = {(iqma_pkg::CS_W + 8)'(sse_reg), 8'd0};
            end
        endcase
    end

    assign trial = {rem_reg, num_reg[iqma_pkg::NUM_W-1]};
    assign fits  = (trial >= {1'b0, den});
    assign q_sat = (|num_reg[iqma_pkg::NUM_W-1:iqma_pkg::RES_W]) ? '1
                                                                  : num_reg[iqma_pkg::RES_W-1:0];

    assign sq     = m_reg * m_reg;
    assign sq_top = sq[2*iqma_pkg::MANT_W-1:iqma_pkg::MANT_W-1];

    assign neg = (ld_reg > ln_reg);
    assign mag = neg ? (ld_reg - ln_reg) : (ln_reg - ld_reg);

    assign scaled = iqma_pkg::PROD_W'(mag) * iqma_pkg::PROD_W'(iqma_pkg::SNR_K);

    assign rnd = {1'b0, prod_reg} + ((iqma_pkg::PROD_W + 1)'(1) << (iqma_pkg::SNR_SHIFT - 1));
    assign q   = rnd[iqma_pkg::PROD_W:iqma_pkg::SNR_SHIFT];

    always_comb
    begin
        if (neg_reg)
        begin
            if (64'(q) > 64'd32768)
                snr = 16'h8000;
            else
                snr = 16'd0 - 16'(q);
        end
        else
        begin
            if (64'(q) > 64'd32767)
                snr = 16'h7FFF;
            else
                snr = 16'(q);
        end
    end

    // accumulators and flags: control state, cleared on reset and after a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scp_reg  <= '0;
            src_reg  <= '0;
            sref_reg <= '0;
            sse_reg  <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.finish)
        begin
            scp_reg  <= '0;
            src_reg  <= '0;
            sref_reg <= '0;
            sse_reg  <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.acc)
        begin
            if (cnt_reg[iqma_pkg::MAX_ITEMS_LOG2])
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                scp_reg  <= scp_reg + iqma_pkg::CS_W'(cs_prod);
                src_reg  <= src_reg + iqma_pkg::CS_W'(cc_prod);
                sref_reg <= sref_reg + iqma_pkg::SREF_W'(c);
                sse_reg  <= sse_reg + iqma_pkg::SSE_W'(dd_prod);
                cnt_reg  <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // restoring divider, one quotient bit per step, quotient lands in num_reg
        if (cmd.div_load)
        begin
            num_reg <= num_in;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? iqma_pkg::CS_W'(trial - {1'b0, den})
                            : trial[iqma_pkg::CS_W-1:0];
            num_reg <= {num_reg[iqma_pkg::NUM_W-2:0], fits};
        end

        if (cmd.div_save)
        begin
            case (cmd.div_sel)
                iqma_pkg::SEL_NC: nc_reg  <= q_sat;
                iqma_pkg::SEL_CQ: cq_reg  <= q_sat;
                default:          mse_reg <= q_sat;
            endcase
        end

        // log2: normalize one bit per cycle, then square the mantissa per fraction bit
        if (cmd.log_load)
        begin
            norm_reg <= cmd.log_sel ? iqma_pkg::NORM_W'(sse_reg) : iqma_pkg::NORM_W'(src_reg);
            e_reg    <= iqma_pkg::E_W'(iqma_pkg::NORM_W - 1);
        end
        else if (cmd.norm)
        begin
            norm_reg <= {norm_reg[iqma_pkg::NORM_W-2:0], 1'b0};
            e_reg    <= e_reg - 1'b1;
        end

        if (cmd.mant_load)
        begin
            m_reg <= norm_reg[iqma_pkg::NORM_W-1 -: iqma_pkg::MANT_W];
            f_reg <= '0;
        end
        else if (cmd.sqr)
        begin
            m_reg <= sq_top[iqma_pkg::MANT_W] ? sq_top[iqma_pkg::MANT_W:1]
                                               : sq_top[iqma_pkg::MANT_W-1:0];
            f_reg <= {f_reg[iqma_pkg::FRAC_W-2:0], sq_top[iqma_pkg::MANT_W]};
        end

        if (cmd.log_save)
        begin
            if (cmd.log_sel)
                ld_reg <= {e_reg, f_reg};
            else
                ln_reg <= {e_reg, f_reg};
        end

        if (cmd.scale)
        begin
            prod_reg <= scaled;
            neg_reg  <= neg;
        end

        if (cmd.finish)
        begin
            out_reg.nc_ratio       <= nc_reg;
            out_reg.cq_ratio       <= cq_reg;
            out_reg.mean_sq_error  <= mse_reg;
            out_reg.snr_db         <= stat.sse_zero ? 16'sh7FFF : $signed(snr);
            out_reg.snr_infinite   <= stat.sse_zero;
            out_reg.pair_count     <= cnt_reg;
            out_reg.count_overflow <= ovf_reg;
        end
    end

    assign stat.norm_done = norm_reg[iqma_pkg::NORM_W-1];
    assign stat.sse_zero  = (sse_reg == '0);
    assign out_data       = out_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

    class metric_scoreboard;
        logic [63:0] s_cs, s_cc, s_c, s_sse, n_seen;
        bit ovf;
        iqma_pkg::iqma_out_t pending[$];
        int errors;
        int results;

        function new();
            s_cs = 0; s_cc = 0; s_c = 0; s_sse = 0; n_seen = 0; ovf = 0;
            errors = 0; results = 0;
        endfunction

        function logic [63:0] log2_q24(logic [63:0] x);
            int e;
            logic [63:0] m, f;
            e = 0;
            f = 0;
            if (x == 0) x = 1;
            while (e < 63 && (x >> (e + 1)) != 0) e++;
            if (e >= 31) m = x >> (e - 31);
            else m = x << (31 - e);
            for (int i = iqma_pkg::FRAC_W - 1; i >= 0; i--) begin
                m = (m * m) >> 31;
                if (m >= 64'h1_0000_0000) begin
                    m = m >> 1;
                    f[i] = 1'b1;
                end
            end
            return (64'(e) << iqma_pkg::FRAC_W) | f;
        endfunction

        function logic [23:0] sat24(logic [63:0] v);
            return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
        endfunction

        function void note_pair(iqma_pkg::iqma_in_t p);
            logic [63:0] c, s, d, ln, ld, mag, q;
            logic [127:0] prod;
            iqma_pkg::iqma_out_t r;
            c = (p.original_byte == 0) ? 1 : p.original_byte;
            s = (p.current_byte == 0) ? 1 : p.current_byte;
            if (n_seen >= (64'd1 << iqma_pkg::MAX_ITEMS_LOG2)) ovf = 1;
            else begin
                d = (c > s) ? c - s : s - c;
                s_cs += c * s;
                s_cc += c * c;
                s_c += c;
                s_sse += d * d;
                n_seen++;
            end
            if (!p.last) return;
            r.nc_ratio = sat24((s_cs << 16) / s_cc);
            r.cq_ratio = sat24((s_cs << 16) / s_c);
            r.mean_sq_error = sat24((s_sse << 8) / n_seen);
            if (s_sse == 0) begin
                r.snr_infinite = 1;
                r.snr_db = 16'sh7FFF;
            end else begin
                ln = log2_q24(s_cc);
                ld = log2_q24(s_sse);
                mag = (ld > ln) ? ld - ln : ln - ld;
                prod = 128'(mag) * 128'(iqma_pkg::SNR_K)
                       + (128'd1 << (iqma_pkg::SNR_SHIFT - 1));
                q = 64'(prod >> iqma_pkg::SNR_SHIFT);
                r.snr_infinite = 0;
                if (ld > ln) begin
                    if (q > 32768) q = 32768;
                    r.snr_db = 16'(17'h10000 - 17'(q));
                end else begin
                    if (q > 32767) q = 32767;
                    r.snr_db = q[15:0];
                end
            end
            r.pair_count = n_seen[iqma_pkg::CNT_W-1:0];
            r.count_overflow = ovf;
            pending.push_back(r);
            s_cs = 0; s_cc = 0; s_c = 0; s_sse = 0; n_seen = 0; ovf = 0;
        endfunction

        function void check_result(iqma_pkg::iqma_out_t a);
            iqma_pkg::iqma_out_t e;
            results++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.nc_ratio !== e.nc_ratio)
                $display("%0t: nc_ratio expected %h actual %h", $time, e.nc_ratio, a.nc_ratio);
            if (a.cq_ratio !== e.cq_ratio)
                $display("%0t: cq_ratio expected %h actual %h", $time, e.cq_ratio, a.cq_ratio);
            if (a.mean_sq_error !== e.mean_sq_error)
                $display("%0t: mean_sq_error expected %h actual %h", $time,
                         e.mean_sq_error, a.mean_sq_error);
            if (a.snr_db !== e.snr_db)
                $display("%0t: snr_db expected %h actual %h", $time, e.snr_db, a.snr_db);
            if (a.snr_infinite !== e.snr_infinite)
                $display("%0t: snr_infinite expected %b actual %b", $time,
                         e.snr_infinite, a.snr_infinite);
            if (a.pair_count !== e.pair_count)
                $display("%0t: pair_count expected %0d actual %0d", $time,
                         e.pair_count, a.pair_count);
            if (a.count_overflow !== e.count_overflow)
                $display("%0t: count_overflow expected %b actual %b", $time,
                         e.count_overflow, a.count_overflow);
            if (a !== e) errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    iqma_pkg::iqma_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 0;
    iqma_pkg::iqma_out_t out_data;

    int send_idle = 0;
    int recv_idle = 0;
    int pairs_sent = 0;
    metric_scoreboard sb = new();

    image_quality_metric_accumulator_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // Drive one request; hold it until taken. Valid stays up for the next caller.
    task send_pair(logic [7:0] c, logic [7:0] s, logic lst);
        iqma_pkg::iqma_in_t p;
        p.original_byte = c;
        p.current_byte = s;
        p.last = lst;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_pair(p);
        pairs_sent++;
    endtask

    task random_set(int len);
        int mode;
        logic [7:0] c, s;
        mode = $urandom_range(3);
        for (int i = 0; i < len; i++)
        begin
            c = 8'($urandom);
            case (mode)
                0: s = 8'($urandom);
                1: s = c;
                2: s = 8'(c + $urandom_range(6) - 3);
                default: s = ($urandom_range(3) == 0) ? 8'd0 : ~c;
            endcase
            if ($urandom_range(15) == 0) c = 0;
            send_pair(c, s, i == len - 1);
        end
    endtask

    task run_phase(int si, int ri, int sets);
        send_idle = si;
        recv_idle = ri;
        for (int k = 0; k < sets; k++)
            random_set(($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, zero bytes, equal streams, single pairs
        send_pair(8'd0, 8'd0, 1);
        send_pair(8'd255, 8'd0, 1);
        send_pair(8'd0, 8'd255, 1);
        send_pair(8'd255, 8'd255, 1);
        send_pair(8'd1, 8'd255, 0);
        send_pair(8'd1, 8'd255, 1);
        send_pair(8'd255, 8'd1, 0);
        send_pair(8'd128, 8'd127, 1);
        send_pair(8'd170, 8'd85, 0);
        send_pair(8'd85, 8'd170, 0);
        send_pair(8'd100, 8'd100, 1);
        send_pair(8'd2, 8'd3, 1);
        run_phase(14, 62, 53);
        run_phase(62, 14, 53);
        run_phase(0, 0, 53);
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        $display("%0d pairs sent in directed and random sets, %0d results checked",
                 pairs_sent, sb.results);
        $display("covered zero bytes, equal streams, extreme bytes and three idling mixes");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/iqma_pkg.sv
design/iqma_ctrl.sv
design/iqma_dp.sv
design/image_quality_metric_accumulator_unit.sv
bench/tb.sv
